/* rtl/core/tedu_pkg.sv */
// ----------------------------------------------------------------------------
// tedu_pkg
// Shared widths, codes, types and helpers of the edge distance unit.
// ----------------------------------------------------------------------------
package tedu_pkg;

    // node store
    localparam int NODE_DEPTH = 1024;
    localparam int NODE_AW    = 10;
    localparam int COORD_W    = 32;
    localparam int NODE_W     = 2 * COORD_W;

    // datapath widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int LO_W   = 16;
    localparam int HI_W   = DIFF_W - LO_W;
    localparam int SQ_W   = 66;
    localparam int ROOT_W = 34;
    localparam int WIDE_W = 72;
    localparam int WORK_W = 35;
    localparam int DIST_W = 33;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int METRIC_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND  = 2'd1;

    // operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // metric codes
    localparam logic [METRIC_W-1:0] METRIC_EUCLID = 3'd0;
    localparam logic [METRIC_W-1:0] METRIC_ATT    = 3'd1;
    localparam logic [METRIC_W-1:0] METRIC_MANH   = 3'd2;
    localparam logic [METRIC_W-1:0] METRIC_CHEB   = 3'd3;
    localparam logic [METRIC_W-1:0] METRIC_CEIL   = 3'd4;

    typedef struct packed {
        logic [DIFF_W-1:0] ax;
        logic [DIFF_W-1:0] ay;
    } diff_t;

    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic                round_int;
    } cfg_t;

    // round Q.8 value to nearest integer, half up
    function automatic logic [WORK_W-1:0] round_half_up(input logic [WORK_W-1:0] v);
        logic [WORK_W-1:0] s;
        s = v + WORK_W'(128);
        return {s[WORK_W-1:8], 8'h00};
    endfunction

endpackage

/* rtl/core/tedu_if.sv */
// ----------------------------------------------------------------------------
// tedu_if
// Valid/ready channels of the edge distance unit: items, results, config.
// ----------------------------------------------------------------------------
interface tedu_in_if;
    import tedu_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [NODE_AW-1:0]        index_a;
    logic [NODE_AW-1:0]        index_b;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;

    modport source (output valid, operation, index_a, index_b, coord_x, coord_y,
                    input ready);
    modport sink   (input valid, operation, index_a, index_b, coord_x, coord_y,
                    output ready);
endinterface

interface tedu_out_if;
    import tedu_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

interface tedu_cfg_if;
    import tedu_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/tedu_front.sv */
// ----------------------------------------------------------------------------
// tedu_front
// Accepts items, writes the node store, reads both nodes of a query and
// forms the absolute coordinate differences.
// ----------------------------------------------------------------------------
module tedu_front (
    input  logic            clk,
    input  logic            rst_n,
    tedu_in_if.sink         in_ch,
    output tedu_pkg::diff_t push_data,
    output logic            push_valid,
    input  logic            push_ready
);
    import tedu_pkg::*;

    logic [NODE_W-1:0] node_mem [NODE_DEPTH];
    logic [NODE_W-1:0] node_a_reg;
    logic [NODE_W-1:0] node_b_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              advance;
    logic              in_fire;
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;

    // read stage moves when empty or when the queue takes its item
    assign advance     = !s1_valid_reg || push_ready;
    assign in_ch.ready = advance;
    assign in_fire     = in_ch.valid && advance;

    assign s1_valid_next = advance ? (in_fire && in_ch.operation == OP_QUERY)
                                   : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // node store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.operation == OP_WRITE)
            node_mem[in_ch.index_a] <= {in_ch.coord_y, in_ch.coord_x};
        if (advance)
        begin
            node_a_reg <= node_mem[in_ch.index_a];
            node_b_reg <= node_mem[in_ch.index_b];
        end
    end

    // absolute differences, sign extended to 33 bits
    always_comb
    begin
        dx = {node_a_reg[COORD_W-1], node_a_reg[COORD_W-1:0]}
           - {node_b_reg[COORD_W-1], node_b_reg[COORD_W-1:0]};
        dy = {node_a_reg[NODE_W-1], node_a_reg[NODE_W-1:COORD_W]}
           - {node_b_reg[NODE_W-1], node_b_reg[NODE_W-1:COORD_W]};
        push_data.ax = dx[DIFF_W-1] ? -dx : dx;
        push_data.ay = dy[DIFF_W-1] ? -dy : dy;
    end

    assign push_valid = s1_valid_reg;

endmodule

/* rtl/core/tedu_queue.sv */
// ----------------------------------------------------------------------------
// tedu_queue
// Two-entry queue of coordinate differences between front and back.
// ----------------------------------------------------------------------------
module tedu_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tedu_pkg::diff_t           push_data,
    input  logic                      push_valid,
    output logic                      push_ready,
    output tedu_pkg::diff_t           pop_data,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output logic [tedu_pkg::QCNT_W-1:0] count
);
    import tedu_pkg::*;

    diff_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/core/tedu_back.sv */
// ----------------------------------------------------------------------------
// tedu_back
// Distance pipeline: split squares, sum, one root bit per stage, then the
// metric rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module tedu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tedu_pkg::cfg_t  cfg,
    input  tedu_pkg::diff_t pop_data,
    input  logic            pop_valid,
    output logic            pop_ready,
    tedu_out_if.source      out_ch
);
    import tedu_pkg::*;

    logic en;
    logic att;

    // stage A: partial products and direct (non-root) result
    logic                   a_valid_reg;
    logic [2*HI_W-1:0]      a_xhh_reg;
    logic [HI_W+LO_W-1:0]   a_xhl_reg;
    logic [2*LO_W-1:0]      a_xll_reg;
    logic [2*HI_W-1:0]      a_yhh_reg;
    logic [HI_W+LO_W-1:0]   a_yhl_reg;
    logic [2*LO_W-1:0]      a_yll_reg;
    logic [WORK_W-1:0]      a_direct_reg;
    logic [WORK_W-1:0]      a_direct_next;

    // stage B: squares, stage C: sum of squares
    logic                   b_valid_reg;
    logic [SQ_W-1:0]        b_sx_reg;
    logic [SQ_W-1:0]        b_sy_reg;
    logic [WORK_W-1:0]      b_direct_reg;
    logic                   c_valid_reg;
    logic [SQ_W-1:0]        c_sum_reg;
    logic [WORK_W-1:0]      c_direct_reg;

    // root stages
    logic [ROOT_W-1:0]      rt_valid_reg;
    logic [ROOT_W-1:0]      rt_valid_next;
    logic [SQ_W-1:0]        rt_rem_reg    [ROOT_W];
    logic [SQ_W-1:0]        rt_rem_next   [ROOT_W];
    logic [ROOT_W-1:0]      rt_root_reg   [ROOT_W];
    logic [ROOT_W-1:0]      rt_root_next  [ROOT_W];
    logic [WORK_W-1:0]      rt_direct_reg [ROOT_W];
    logic [WORK_W-1:0]      rt_direct_next[ROOT_W];

    // output register
    logic                   o_valid_reg;
    logic [DIST_W-1:0]      o_dist_reg;
    logic [DIST_W-1:0]      o_dist_next;

    // whole pipeline moves together, held only by a stalled output
    assign en        = !o_valid_reg || out_ch.ready;
    assign pop_ready = en;
    assign att       = cfg.metric == METRIC_ATT;

    // Manhattan and Chebyshev results
    always_comb
    begin
        logic [WORK_W-1:0] sum;
        logic [WORK_W-1:0] cx;
        logic [WORK_W-1:0] cy;
        logic [WORK_W-1:0] cheb;
        sum  = WORK_W'(pop_data.ax) + WORK_W'(pop_data.ay);
        cx   = cfg.round_int ? round_half_up(WORK_W'(pop_data.ax)) : WORK_W'(pop_data.ax);
        cy   = cfg.round_int ? round_half_up(WORK_W'(pop_data.ay)) : WORK_W'(pop_data.ay);
        cheb = (cx > cy) ? cx : cy;
        if (cfg.metric == METRIC_MANH)
            a_direct_next = cfg.round_int ? round_half_up(sum) : sum;
        else
            a_direct_next = cheb;
    end

    // one root bit per stage: keep r with k*r^2 <= S, k = 10 for ATT
    always_comb
    begin
        logic              pv;
        logic [SQ_W-1:0]   prem;
        logic [ROOT_W-1:0] proot;
        logic [WORK_W-1:0] pdir;
        logic [WIDE_W-1:0] trial;
        logic [WIDE_W-1:0] cost;
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (i == 0)
            begin
                pv    = c_valid_reg;
                prem  = c_sum_reg;
                proot = '0;
                pdir  = c_direct_reg;
            end
            else
            begin
                pv    = rt_valid_reg[i-1];
                prem  = rt_rem_reg[i-1];
                proot = rt_root_reg[i-1];
                pdir  = rt_direct_reg[i-1];
            end
            trial = (WIDE_W'(proot) << (ROOT_W - i))
                  | (WIDE_W'(1) << (2 * (ROOT_W - 1 - i)));
            cost  = att ? ((trial << 3) + (trial << 1)) : trial;
            rt_valid_next[i]  = pv;
            rt_direct_next[i] = pdir;
            if (cost <= WIDE_W'(prem))
            begin
                rt_rem_next[i]  = prem - cost[SQ_W-1:0];
                rt_root_next[i] = proot | (ROOT_W'(1) << (ROOT_W - 1 - i));
            end
            else
            begin
                rt_rem_next[i]  = prem;
                rt_root_next[i] = proot;
            end
        end
    end

    // metric finish and saturation
    always_comb
    begin
        logic [ROOT_W-1:0] r;
        logic [WORK_W-1:0] r35;
        logic [WORK_W-1:0] res;
        logic              inexact;
        r       = rt_root_reg[ROOT_W-1];
        r35     = WORK_W'(r);
        inexact = (|r[7:0]) || (|rt_rem_reg[ROOT_W-1]);
        unique case (cfg.metric) inside
            METRIC_ATT:
            begin
                if (cfg.round_int)
                begin
                    res = round_half_up(r35);
                    if (!r[7] && inexact)
                        res = res + WORK_W'(256);
                end
                else
                    res = r35;
            end
            METRIC_CEIL:
            begin
                res = {r35[WORK_W-1:8], 8'h00};
                if (inexact)
                    res = res + WORK_W'(256);
            end
            METRIC_MANH, METRIC_CHEB:
                res = rt_direct_reg[ROOT_W-1];
            default:
                res = cfg.round_int ? round_half_up(r35) : r35;
        endcase
        if (|res[WORK_W-1:DIST_W])
            o_dist_next = '1;
        else
            o_dist_next = res[DIST_W-1:0];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            rt_valid_reg <= '0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg  <= pop_valid;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            rt_valid_reg <= rt_valid_next;
            o_valid_reg  <= rt_valid_reg[ROOT_W-1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_xhh_reg    <= pop_data.ax[DIFF_W-1:LO_W] * pop_data.ax[DIFF_W-1:LO_W];
            a_xhl_reg    <= pop_data.ax[DIFF_W-1:LO_W] * pop_data.ax[LO_W-1:0];
            a_xll_reg    <= pop_data.ax[LO_W-1:0] * pop_data.ax[LO_W-1:0];
            a_yhh_reg    <= pop_data.ay[DIFF_W-1:LO_W] * pop_data.ay[DIFF_W-1:LO_W];
            a_yhl_reg    <= pop_data.ay[DIFF_W-1:LO_W] * pop_data.ay[LO_W-1:0];
            a_yll_reg    <= pop_data.ay[LO_W-1:0] * pop_data.ay[LO_W-1:0];
            a_direct_reg <= a_direct_next;

            b_sx_reg     <= (SQ_W'(a_xhh_reg) << (2 * LO_W))
                          + (SQ_W'(a_xhl_reg) << (LO_W + 1)) + SQ_W'(a_xll_reg);
            b_sy_reg     <= (SQ_W'(a_yhh_reg) << (2 * LO_W))
                          + (SQ_W'(a_yhl_reg) << (LO_W + 1)) + SQ_W'(a_yll_reg);
            b_direct_reg <= a_direct_reg;

            c_sum_reg    <= b_sx_reg + b_sy_reg;
            c_direct_reg <= b_direct_reg;

            for (int i = 0; i < ROOT_W; i++)
            begin
                rt_rem_reg[i]    <= rt_rem_next[i];
                rt_root_reg[i]   <= rt_root_next[i];
                rt_direct_reg[i] <= rt_direct_next[i];
            end

            o_dist_reg <= o_dist_next;
        end
    end

    assign out_ch.valid    = o_valid_reg;
    assign out_ch.distance = o_dist_reg;

endmodule

/* rtl/core/tsp_edge_distance_unit.sv */
// Throughput: one item per cycle unless the output stalls; the root is one bit per
// pipeline stage over 34 stages, after the read stage, queue and stages A, B and C.
// A two-entry queue decouples the node store read stage from the distance pipeline.
// Reset clears all valid and control state and the metric/rounding registers.
// Node store contents are undefined until written; reset does not clear them.
// ----------------------------------------------------------------------------
// tsp_edge_distance_unit
// Node coordinate store with a pipelined distance engine for five metrics.
// ----------------------------------------------------------------------------
module tsp_edge_distance_unit (
    input  logic       clk,
    input  logic       rst_n,
    tedu_in_if.sink    in_ch,
    tedu_out_if.source out_ch,
    tedu_cfg_if.sink   cfg_ch
);
    import tedu_pkg::*;

    cfg_t              cfg_reg;
    diff_t             push_data;
    logic              push_valid;
    logic              push_ready;
    diff_t             pop_data;
    logic              pop_valid;
    logic              pop_ready;
    logic [QCNT_W-1:0] q_count;
    logic              cfg_fire;

    // configuration registers
    assign cfg_ch.ready = 1'b1;
    assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_fire)
        begin
            unique case (cfg_ch.index)
                CFG_METRIC: cfg_reg.metric    <= cfg_ch.data[METRIC_W-1:0];
                CFG_ROUND:  cfg_reg.round_int <= cfg_ch.data[0];
                default:    ;
            endcase
        end
    end

    tedu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    tedu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .count      (q_count)
    );

    tedu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // front stalls only behind a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> q_count == QCNT_W'(QUEUE_DEPTH))
        else $error("input stalled with queue space");

    // a metric write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire && cfg_ch.index == CFG_METRIC |=> cfg_reg.metric == $past(cfg_ch.data))
        else $error("metric write lost");

endmodule
